// ===== rtl/core/jbl_pkg.sv =====
// ----------------------------------------------------------------------------
// jbl_pkg
// Types and constants shared by the JSON byte lexer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package jbl_pkg;

   localparam int VAL_BITS = 63;
   localparam logic [62:0] VAL_MAX = {63{1'b1}};

   typedef enum logic [3:0] {
      TK_LBRACE  = 4'd0,
      TK_RBRACE  = 4'd1,
      TK_LBRACK  = 4'd2,
      TK_RBRACK  = 4'd3,
      TK_COMMA   = 4'd4,
      TK_COLON   = 4'd5,
      TK_STRING  = 4'd6,
      TK_INT     = 4'd7,
      TK_DEC     = 4'd8,
      TK_TRUE    = 4'd9,
      TK_FALSE   = 4'd10,
      TK_NULL    = 4'd11,
      TK_END     = 4'd12,
      TK_SBYTE   = 4'd13,
      TK_ERROR   = 4'd14
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_STR  = 3'd1,
      MODE_INT  = 3'd2,
      MODE_FRAC = 3'd3,
      MODE_KEY  = 3'd4,
      MODE_ERR  = 3'd5
   } mode_type;

   // one result word carried from front to back
   typedef struct packed {
      kind_type     kind;
      logic [15:0]  line;
      logic [15:0]  col;
      logic [62:0]  int_val;
      logic [62:0]  frac_val;
      logic [7:0]   frac_cnt;
      logic [7:0]   text;
      logic [15:0]  len;
      logic         last;
   } token_type;

   function automatic logic [7:0] kw_char(input logic [1:0] kk, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (kk)
         2'd0: begin
            case (pos)
               3'd0: c = "t";
               3'd1: c = "r";
               3'd2: c = "u";
               3'd3: c = "e";
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            case (pos)
               3'd0: c = "f";
               3'd1: c = "a";
               3'd2: c = "l";
               3'd3: c = "s";
               3'd4: c = "e";
               default: c = 8'h00;
            endcase
         end
         2'd2: begin
            case (pos)
               3'd0: c = "n";
               3'd1: c = "u";
               3'd2: c = "l";
               3'd3: c = "l";
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] kk);
      return (kk == 2'd1) ? 3'd5 : 3'd4;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/jbl_front.sv =====
// ----------------------------------------------------------------------------
// jbl_front
// Accepts bytes, tracks position and lexer state, and produces up to two
// token words per byte.
// ----------------------------------------------------------------------------
`default_nettype none
module jbl_front #(
   parameter int POS_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                allow_sq,
   input  wire logic                take,
   input  wire logic [7:0]          char_byte,
   input  wire logic                doc_end,
   output jbl_pkg::token_type       tok0,
   output jbl_pkg::token_type       tok1,
   output logic                     tok0_vld,
   output logic                     tok1_vld
);

   localparam int PW = (POS_BITS < 16) ? POS_BITS : 16;
   localparam logic [15:0] PMAX = 16'((32'd1 << PW) - 32'd1);

   jbl_pkg::mode_type mode_ff, mode_in;
   logic        quote_ff, quote_in;
   logic [1:0]  kk_ff, kk_in;
   logic [2:0]  kpos_ff, kpos_in;
   logic [15:0] line_ff, line_in, col_ff, col_in, sline_ff, sline_in, scol_ff, scol_in;
   logic [62:0] iacc_ff, iacc_in, facc_ff, facc_in;
   logic [7:0]  fcnt_ff, fcnt_in;
   logic [15:0] slen_ff, slen_in;

   function automatic logic [15:0] pinc(input logic [15:0] x);
      return (x < PMAX) ? x + 16'd1 : x;
   endfunction

   // saturating acc*10+d; the 67-bit product is a constant shift-add
   function automatic logic [62:0] dacc(input logic [62:0] a, input logic [3:0] d);
      logic [66:0] p;
      p = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {63'd0, d};
      return (p > {4'd0, jbl_pkg::VAL_MAX}) ? jbl_pkg::VAL_MAX : p[62:0];
   endfunction

   function automatic jbl_pkg::token_type mk(input jbl_pkg::kind_type k,
                                             input logic [15:0] l, input logic [15:0] c);
      jbl_pkg::token_type t;
      t = '0;
      t.kind = k;
      t.line = l;
      t.col = c;
      return t;
   endfunction

   always_comb begin
      jbl_pkg::token_type t0, t1, t;
      logic v0, v1, is_dig, done, punct, emit_num;
      jbl_pkg::kind_type pk;
      mode_in = mode_ff; quote_in = quote_ff; kk_in = kk_ff; kpos_in = kpos_ff;
      line_in = line_ff; col_in = col_ff; sline_in = sline_ff; scol_in = scol_ff;
      iacc_in = iacc_ff; facc_in = facc_ff; fcnt_in = fcnt_ff; slen_in = slen_ff;
      t0 = '0; t1 = '0; t = '0; v0 = 1'b0; v1 = 1'b0; done = 1'b0; emit_num = 1'b0;
      pk = jbl_pkg::TK_LBRACE; punct = 1'b0;
      is_dig = (char_byte >= "0") && (char_byte <= "9");
      // number token from current accumulators
      t = mk((mode_ff == jbl_pkg::MODE_FRAC) ? jbl_pkg::TK_DEC : jbl_pkg::TK_INT,
             sline_ff, scol_ff);
      t.int_val = iacc_ff;
      if (mode_ff == jbl_pkg::MODE_FRAC) begin
         t.frac_val = facc_ff;
         t.frac_cnt = fcnt_ff;
      end
      if (mode_ff == jbl_pkg::MODE_ERR) begin
         t0 = mk(jbl_pkg::TK_ERROR, sline_ff, scol_ff); v0 = 1'b1;
      end else if (doc_end) begin
         if (mode_ff == jbl_pkg::MODE_STR || mode_ff == jbl_pkg::MODE_KEY) begin
            t0 = mk(jbl_pkg::TK_ERROR, line_ff, col_ff); v0 = 1'b1;
            sline_in = line_ff; scol_in = col_ff; mode_in = jbl_pkg::MODE_ERR;
         end else begin
            if (mode_ff == jbl_pkg::MODE_INT || mode_ff == jbl_pkg::MODE_FRAC) begin
               t0 = t; v0 = 1'b1;
               t1 = mk(jbl_pkg::TK_END, line_ff, col_ff); v1 = 1'b1;
            end else begin
               t0 = mk(jbl_pkg::TK_END, line_ff, col_ff); v0 = 1'b1;
            end
            mode_in = jbl_pkg::MODE_IDLE; quote_in = 1'b0; kk_in = '0; kpos_in = '0;
            line_in = 16'd1; col_in = 16'd1; sline_in = '0; scol_in = '0;
            iacc_in = '0; facc_in = '0; fcnt_in = '0; slen_in = '0;
         end
      end else if (mode_ff == jbl_pkg::MODE_STR) begin
         if (char_byte == (quote_ff ? 8'h27 : 8'h22)) begin
            t0 = mk(jbl_pkg::TK_STRING, sline_ff, scol_ff);
            t0.len = slen_ff;
            mode_in = jbl_pkg::MODE_IDLE;
         end else begin
            t0 = mk(jbl_pkg::TK_SBYTE, line_ff, col_ff);
            t0.text = char_byte;
            slen_in = pinc(slen_ff);
         end
         v0 = 1'b1; col_in = pinc(col_ff);
      end else if ((mode_ff == jbl_pkg::MODE_INT || mode_ff == jbl_pkg::MODE_FRAC)
                   && (is_dig || (char_byte == "." && mode_ff == jbl_pkg::MODE_INT))) begin
         if (!is_dig) mode_in = jbl_pkg::MODE_FRAC;
         else if (mode_ff == jbl_pkg::MODE_INT) iacc_in = dacc(iacc_ff, char_byte[3:0]);
         else begin
            facc_in = dacc(facc_ff, char_byte[3:0]);
            if (fcnt_ff != 8'hFF) fcnt_in = fcnt_ff + 8'd1;
         end
         col_in = pinc(col_ff);
      end else if (mode_ff == jbl_pkg::MODE_KEY) begin
         if (kk_ff != 2'd3 && kpos_ff < jbl_pkg::kw_len(kk_ff)
             && char_byte == jbl_pkg::kw_char(kk_ff, kpos_ff)) begin
            kpos_in = kpos_ff + 3'd1;
            col_in = pinc(col_ff);
            if (kpos_ff + 3'd1 >= jbl_pkg::kw_len(kk_ff)) begin
               t0 = mk(jbl_pkg::kind_type'(4'(jbl_pkg::TK_TRUE) + {2'd0, kk_ff}),
                       sline_ff, scol_ff);
               v0 = 1'b1; mode_in = jbl_pkg::MODE_IDLE; kpos_in = '0;
            end
         end else begin
            t0 = mk(jbl_pkg::TK_ERROR, line_ff, col_ff); v0 = 1'b1;
            sline_in = line_ff; scol_in = col_ff; mode_in = jbl_pkg::MODE_ERR;
         end
      end else begin
         // idle lexing, possibly after closing a number
         emit_num = (mode_ff == jbl_pkg::MODE_INT || mode_ff == jbl_pkg::MODE_FRAC);
         mode_in = jbl_pkg::MODE_IDLE;
         done = 1'b0;
         case (char_byte)
            8'h20, 8'h09, 8'h0D: begin col_in = pinc(col_ff); done = 1'b1; end
            8'h0A: begin line_in = pinc(line_ff); col_in = 16'd1; done = 1'b1; end
            "{": begin pk = jbl_pkg::TK_LBRACE; punct = 1'b1; end
            "}": begin pk = jbl_pkg::TK_RBRACE; punct = 1'b1; end
            "[": begin pk = jbl_pkg::TK_LBRACK; punct = 1'b1; end
            "]": begin pk = jbl_pkg::TK_RBRACK; punct = 1'b1; end
            ",": begin pk = jbl_pkg::TK_COMMA; punct = 1'b1; end
            ":": begin pk = jbl_pkg::TK_COLON; punct = 1'b1; end
            default: punct = 1'b0;
         endcase
         t1 = '0;
         if (!done) begin
            if (punct) begin
               t1 = mk(pk, line_ff, col_ff); v1 = 1'b1;
               col_in = pinc(col_ff);
            end else begin
               sline_in = line_ff; scol_in = col_ff; col_in = pinc(col_ff);
               if (char_byte == 8'h22 || (char_byte == 8'h27 && allow_sq)) begin
                  quote_in = (char_byte == 8'h27); slen_in = '0;
                  mode_in = jbl_pkg::MODE_STR;
               end else if (is_dig) begin
                  iacc_in = {59'd0, char_byte[3:0]}; facc_in = '0; fcnt_in = '0;
                  mode_in = jbl_pkg::MODE_INT;
               end else if (char_byte == "t" || char_byte == "f" || char_byte == "n") begin
                  kk_in = (char_byte == "t") ? 2'd0 : (char_byte == "f") ? 2'd1 : 2'd2;
                  kpos_in = 3'd1; mode_in = jbl_pkg::MODE_KEY;
               end else begin
                  col_in = col_ff;
                  t1 = mk(jbl_pkg::TK_ERROR, line_ff, col_ff); v1 = 1'b1;
                  mode_in = jbl_pkg::MODE_ERR;
               end
            end
         end
         if (emit_num) begin
            t0 = t; v0 = 1'b1;
         end else begin
            t0 = t1; v0 = v1; t1 = '0; v1 = 1'b0;
         end
      end
      if (v1) t1.last = 1'b1;
      else if (v0) t0.last = 1'b1;
      tok0 = t0; tok1 = t1; tok0_vld = v0; tok1_vld = v1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jbl_pkg::MODE_IDLE; quote_ff <= 1'b0; kk_ff <= '0; kpos_ff <= '0;
         line_ff <= 16'd1; col_ff <= 16'd1; sline_ff <= '0; scol_ff <= '0;
         iacc_ff <= '0; facc_ff <= '0; fcnt_ff <= '0; slen_ff <= '0;
      end else if (take) begin
         mode_ff <= mode_in; quote_ff <= quote_in; kk_ff <= kk_in; kpos_ff <= kpos_in;
         line_ff <= line_in; col_ff <= col_in; sline_ff <= sline_in; scol_ff <= scol_in;
         iacc_ff <= iacc_in; facc_ff <= facc_in; fcnt_ff <= fcnt_in; slen_ff <= slen_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/jbl_queue.sv =====
// ----------------------------------------------------------------------------
// jbl_queue
// Four-entry token queue between front and back; takes up to two words a
// cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none
module jbl_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  jbl_pkg::token_type      wr0,
   input  jbl_pkg::token_type      wr1,
   input  wire logic               wr0_en,
   input  wire logic               wr1_en,
   output logic                    room2,
   output jbl_pkg::token_type      rd,
   output logic                    rd_vld,
   input  wire logic               rd_en
);

   jbl_pkg::token_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic [1:0] nwr;

   assign nwr = {1'b0, wr0_en} + {1'b0, wr1_en};
   assign room2 = (cnt_ff <= 3'd2);
   assign rd_vld = (cnt_ff != 3'd0);
   assign rd = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr0_en) mem_ff[wp_ff] <= wr0;
      if (wr1_en) mem_ff[wp_ff + {1'b0, wr0_en}] <= wr1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + nwr;
         if (rd_en && rd_vld) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {1'b0, nwr} - {2'b0, (rd_en && rd_vld)};
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/json_byte_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// json_byte_lexer_unit
// Byte-serial JSON tokenizer with queue-style ports.
// ----------------------------------------------------------------------------
// Latency: tokens from a pushed byte are registered in the token queue before they appear on rsp_.
// Throughput: one byte per cycle while the four-word token queue has room for two
// words; full is raised and no byte is taken until the queue has that room again.
// Reset: synchronous; clears lexer state and queue, allow_single_quote to 1.
`default_nettype none
module json_byte_lexer_unit #(
   parameter int POS_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   input  wire logic         push,
   output logic              full,
   input  wire logic [7:0]   req_char_byte,
   input  wire logic         req_doc_end,
   output logic              empty,
   input  wire logic         pop,
   output logic [3:0]        rsp_token_kind,
   output logic [15:0]       rsp_token_line,
   output logic [15:0]       rsp_token_col,
   output logic [62:0]       rsp_int_value,
   output logic [62:0]       rsp_frac_value,
   output logic [7:0]        rsp_frac_digits,
   output logic [7:0]        rsp_text_byte,
   output logic [15:0]       rsp_text_length,
   output logic              rsp_last_of_run
);

   logic allow_sq_ff;
   logic take, room2, v0, v1, rdv;
   jbl_pkg::token_type t0, t1, rd;

   always_ff @(posedge clock) begin
      if (reset) allow_sq_ff <= 1'b1;
      else if (csr_we) allow_sq_ff <= csr_wdata;
   end

   assign full = !room2;
   assign take = push && room2;

   jbl_front #(.POS_BITS(POS_BITS)) u_front (
      .clock(clock), .reset(reset), .allow_sq(allow_sq_ff), .take(take),
      .char_byte(req_char_byte), .doc_end(req_doc_end),
      .tok0(t0), .tok1(t1), .tok0_vld(v0), .tok1_vld(v1)
   );

   jbl_queue u_queue (
      .clock(clock), .reset(reset), .wr0(t0), .wr1(t1),
      .wr0_en(take && v0), .wr1_en(take && v1), .room2(room2),
      .rd(rd), .rd_vld(rdv), .rd_en(pop)
   );

   assign empty = !rdv;
   assign rsp_token_kind = rd.kind;
   assign rsp_token_line = rd.line;
   assign rsp_token_col = rd.col;
   assign rsp_int_value = rd.int_val;
   assign rsp_frac_value = rd.frac_val;
   assign rsp_frac_digits = rd.frac_cnt;
   assign rsp_text_byte = rd.text;
   assign rsp_text_length = rd.len;
   assign rsp_last_of_run = rd.last;

endmodule
`default_nettype wire

// ===== rtl/core/jbl_checker.sv =====
// ----------------------------------------------------------------------------
// jbl_checker
// Port-level checks for the JSON byte lexer.
// ----------------------------------------------------------------------------
`default_nettype none
module jbl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [3:0] rsp_token_kind,
   input wire logic       rsp_last_of_run
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("queue not empty after reset");
   a_not_full_after_reset: assert property (@(posedge clock) reset |=> !full)
      else $error("full after reset");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_token_kind <= jbl_pkg::TK_ERROR)
      else $error("bad token kind");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind == jbl_pkg::TK_END) |-> rsp_last_of_run)
      else $error("end token not last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop && !push) |=> !empty)
      else $error("result lost");

endmodule

bind json_byte_lexer_unit jbl_checker u_jbl_checker (
   .clock(clock), .reset(reset), .push(push), .full(full), .empty(empty),
   .pop(pop), .rsp_token_kind(rsp_token_kind), .rsp_last_of_run(rsp_last_of_run)
);
`default_nettype wire
